### rtl/led_matrix_bitplane_scanner_assert.svh
// ----------------------------------------------------------------------------
// led_matrix_bitplane_scanner_assert.svh
// assertion macros shared by the scanner rtl
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_BITPLANE_SCANNER_ASSERT_SVH
`define LED_MATRIX_BITPLANE_SCANNER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define LMBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LMBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lmbs_pkg.sv
// ----------------------------------------------------------------------------
// lmbs_pkg
// types and constants of the led matrix bit-plane scanner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lmbs_pkg;

  // rows held per plane in the frame store
  localparam int unsigned StoreRows = 16;

  localparam logic [7:0] RstPeriodP0  = 8'd2;
  localparam logic [7:0] RstPeriodP1  = 8'd8;
  localparam logic [7:0] RstPeriodP2  = 8'd20;
  localparam logic [7:0] RstStartup   = 8'h20;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_PERIOD_P0 = 2'd0,
    REG_PERIOD_P1 = 2'd1,
    REG_PERIOD_P2 = 2'd2,
    REG_STARTUP   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [1:0]  write_plane;
    logic [3:0]  write_row;
    logic [15:0] write_word;
  } in_t;

  typedef struct packed {
    logic [15:0] column_bits;
    logic        chain_reset;
    logic        first_chain_data;
    logic        second_chain_data;
    logic [3:0]  shown_row;
    logic [1:0]  shown_plane;
  } out_t;

  // row step as seen by the tick now offered
  typedef struct packed {
    logic       fire;
    logic       first;
    logic       second;
    logic [3:0] row;
    logic [1:0] plane;
  } step_t;

endpackage

`default_nettype wire

### rtl/lmbs_ram.sv
// ----------------------------------------------------------------------------
// lmbs_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lmbs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 48,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/lmbs_ctrl.sv
// ----------------------------------------------------------------------------
// lmbs_ctrl
// tick, row and plane counters with the period registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lmbs_ctrl #(
  parameter int unsigned PLANES             = 3,
  parameter int unsigned ROWS               = 16,
  parameter int unsigned SECOND_CHAIN_START = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                tick_acc_i,
  input  wire logic                cfg_we_i,
  input  wire lmbs_pkg::cfg_idx_e  cfg_idx_i,
  input  wire logic [7:0]          cfg_data_i,
  output lmbs_pkg::step_t          step_o
);
  import lmbs_pkg::*;

  logic [7:0] tick_q, tick_d;
  logic [7:0] period_q, period_d;
  logic [3:0] row_q, row_d;
  logic [1:0] plane_q, plane_d;
  logic [7:0] per_p0_q, per_p1_q, per_p2_q;

  logic       fire;
  logic       first;
  logic [1:0] plane_inc;
  logic [1:0] plane_nxt;
  logic [7:0] plane_per;

  assign fire      = (tick_q == period_q);
  assign first     = (row_q == 4'd0);
  assign plane_inc = plane_q + 2'd1;
  assign plane_nxt = (plane_inc >= 2'(PLANES)) ? 2'd0 : plane_inc;

  always_comb begin
    unique case (plane_nxt)
      2'd0:    plane_per = per_p0_q;
      2'd1:    plane_per = per_p1_q;
      default: plane_per = per_p2_q;
    endcase
  end

  always_comb begin
    step_o.fire   = fire;
    step_o.first  = first;
    step_o.second = !first && (row_q == 4'(SECOND_CHAIN_START));
    step_o.row    = row_q;
    step_o.plane  = first ? plane_nxt : plane_q;
  end

  always_comb begin
    tick_d   = tick_q;
    row_d    = row_q;
    plane_d  = plane_q;
    period_d = period_q;
    if (cfg_we_i && (cfg_idx_i == REG_STARTUP)) begin
      period_d = cfg_data_i;
    end else if (tick_acc_i) begin
      if (fire) begin
        tick_d = 8'd0;
        row_d  = (row_q == 4'(ROWS - 1)) ? 4'd0 : row_q + 4'd1;
        if (first) begin
          plane_d  = plane_nxt;
          period_d = plane_per;
        end
      end else begin
        tick_d = tick_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= 8'd0;
      row_q    <= 4'd0;
      plane_q  <= 2'd0;
      period_q <= RstStartup;
    end else begin
      tick_q   <= tick_d;
      row_q    <= row_d;
      plane_q  <= plane_d;
      period_q <= period_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_p0_q <= RstPeriodP0;
      per_p1_q <= RstPeriodP1;
      per_p2_q <= RstPeriodP2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PERIOD_P0: per_p0_q <= cfg_data_i;
        REG_PERIOD_P1: per_p1_q <= cfg_data_i;
        REG_PERIOD_P2: per_p2_q <= cfg_data_i;
        // startup value only lives on in period_q
        REG_STARTUP:   ;
      endcase
    end
  end

`include "led_matrix_bitplane_scanner_assert.svh"

  `LMBS_ASSERT_NOW(a_plane_rng, 1'b1, 32'(plane_q) < PLANES,
                   "plane counter beyond plane count")
  `LMBS_ASSERT_NOW(a_row_rng, 1'b1, 32'(row_q) < ROWS,
                   "row counter beyond row count")
  `LMBS_ASSERT_NXT(a_step_adv, tick_acc_i && fire && !cfg_we_i,
                   (tick_q == 8'd0) && (row_q != $past(row_q)),
                   "row step did not clear tick and advance row")

endmodule

`default_nettype wire

### rtl/led_matrix_bitplane_scanner.sv
// ----------------------------------------------------------------------------
// led_matrix_bitplane_scanner
// 16-row led matrix scanner with bit-plane frame store and binary code
// modulation
// ----------------------------------------------------------------------------
// Input requests (in_valid_i / in_stall_o) are either a frame word write or
// one prescaled timer tick. A tick that reaches the current period fires a
// row step, which produces one output request (out_valid_o / out_stall_i)
// with the column word for the shown plane and row plus the row-chain pulses.
// Other ticks and all writes produce nothing.
// Throughput: one request per clock while in_stall_o is low. A row step
// appears on the output in the cycle after its tick is taken, through the
// registered read port of the frame store ram.
// Config writes (cfg_valid_i / cfg_ready_o) are always taken
// and must only be issued while the block is idle.
// Reset: counters clear, periods load their defaults and every frame word
// reads as zero until written (per-entry valid flops, no clearing pass).
// A stalled output holds its result; writes and non-firing ticks are still
// taken meanwhile, only a tick that would fire another step is stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module led_matrix_bitplane_scanner #(
  parameter int unsigned PLANES             = 3,
  parameter int unsigned ROWS               = 16,
  parameter int unsigned SECOND_CHAIN_START = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire lmbs_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output lmbs_pkg::out_t      out_data_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [7:0]     cfg_data_i
);
  import lmbs_pkg::*;

  localparam int unsigned DEPTH = PLANES * StoreRows;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  step_t          step;
  logic           in_acc;
  logic           tick_acc;
  logic           step_acc;
  logic           wr_acc;
  logic [5:0]     wr_full;
  logic [5:0]     rd_full;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  logic [15:0]    rdata;

  logic [DEPTH-1:0] vld_q;
  logic             rd_vld_q;
  logic             out_vld_q, out_vld_d;
  step_t            meta_q;

  assign cfg_ready_o = 1'b1;

  assign in_stall_o = out_vld_q && out_stall_i && (in_data_i.cmd == CMD_TICK) && step.fire;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tick_acc   = in_acc && (in_data_i.cmd == CMD_TICK);
  assign step_acc   = tick_acc && step.fire;
  assign wr_acc     = in_acc && (in_data_i.cmd == CMD_WRITE)
                      && (32'(in_data_i.write_plane) < PLANES);

  assign wr_full = {in_data_i.write_plane, in_data_i.write_row};
  assign rd_full = {step.plane, step.row};
  assign wr_addr = wr_full[AW-1:0];
  assign rd_addr = rd_full[AW-1:0];

  lmbs_ctrl #(
    .PLANES             (PLANES),
    .ROWS               (ROWS),
    .SECOND_CHAIN_START (SECOND_CHAIN_START)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_acc_i (tick_acc),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_idx_i  (cfg_idx_e'(cfg_index_i)),
    .cfg_data_i (cfg_data_i),
    .step_o     (step)
  );

  lmbs_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_acc),
    .waddr_i (wr_addr),
    .wdata_i (in_data_i.write_word),
    .re_i    (step_acc),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // entries never written read back as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_acc) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    priority if (step_acc) begin
      out_vld_d = 1'b1;
    end else if (out_stall_i) begin
      out_vld_d = out_vld_q;
    end else begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_acc) begin
      meta_q   <= step;
      rd_vld_q <= vld_q[rd_addr];
    end
  end

  assign out_valid_o = out_vld_q;

  always_comb begin
    out_data_o.column_bits       = rd_vld_q ? rdata : 16'd0;
    out_data_o.chain_reset       = meta_q.first || meta_q.second;
    out_data_o.first_chain_data  = meta_q.first;
    out_data_o.second_chain_data = meta_q.second;
    out_data_o.shown_row         = meta_q.row;
    out_data_o.shown_plane       = meta_q.plane;
  end

`include "led_matrix_bitplane_scanner_assert.svh"

  `LMBS_ASSERT_NOW(a_no_overrun, out_vld_q && out_stall_i, !step_acc,
                   "row step taken over a held result")
  `LMBS_ASSERT_NOW(a_chain_bits, out_vld_q,
                   !(meta_q.first && meta_q.second) && (meta_q.first == (meta_q.row == 4'd0)),
                   "chain pulses inconsistent with row")
  `LMBS_ASSERT_NOW(a_meta_fire, out_vld_q, meta_q.fire,
                   "held result not captured from a firing tick")
  `LMBS_ASSERT_NXT(a_wr_valid, wr_acc, vld_q[$past(wr_addr)],
                   "written entry not marked valid")

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the led matrix bit-plane scanner: frame writes and
// timer ticks go in through a queued driver, a clocked monitor predicts each
// row step from its own copy of the scan state and compares every output
// request field by field, while register settings change between phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import lmbs_pkg::*;

  localparam int unsigned Planes           = 3;
  localparam int unsigned Rows             = 16;
  localparam int unsigned SecondChainStart = 8;
  localparam int unsigned CycleLimit       = 400000;
  localparam int unsigned DrainCycles      = 8;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i  = '0;

  // scan state as the block should hold it
  logic [15:0] frame_words [Planes][StoreRows];
  logic [7:0]  plane_periods [Planes];
  logic [7:0]  active_period;
  logic [7:0]  tick_count;
  logic [3:0]  scan_row;
  logic [1:0]  scan_plane;

  in_t         queued_reqs [$];
  out_t        pending_steps [$];
  logic        req_accepted = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  led_matrix_bitplane_scanner #(
    .PLANES             (Planes),
    .ROWS               (Rows),
    .SECOND_CHAIN_START (SecondChainStart)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic note_error(input string what, input logic [31:0] got,
                            input logic [31:0] want);
    $display("ERROR at %0t ns: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic reset_scanner_model();
    foreach (frame_words[p, r]) frame_words[p][r] = '0;
    plane_periods[0] = RstPeriodP0;
    plane_periods[1] = RstPeriodP1;
    plane_periods[2] = RstPeriodP2;
    active_period    = RstStartup;
    tick_count       = '0;
    scan_row         = '0;
    scan_plane       = '0;
  endtask

  task automatic load_register(input cfg_idx_e idx, input logic [7:0] value);
    case (idx)
      REG_PERIOD_P0: plane_periods[0] = value;
      REG_PERIOD_P1: plane_periods[1] = value;
      REG_PERIOD_P2: plane_periods[2] = value;
      // the startup value takes over the compare at once
      REG_STARTUP:   active_period = value;
      default: ;
    endcase
  endtask

  task automatic advance_scanner(input in_t req);
    out_t step;
    step = '0;
    if (req.cmd == CMD_WRITE) begin
      if (req.write_plane < Planes)
        frame_words[req.write_plane][req.write_row] = req.write_word;
    end else if (tick_count != active_period) begin
      tick_count = tick_count + 8'd1;
    end else begin
      tick_count = '0;
      step.shown_row = scan_row;
      if (scan_row == 4'd0) begin
        step.first_chain_data = 1'b1;
        scan_plane = (int'(scan_plane) + 1 >= Planes) ? 2'd0 : scan_plane + 2'd1;
        active_period = plane_periods[scan_plane];
      end else if (scan_row == SecondChainStart) begin
        step.second_chain_data = 1'b1;
      end
      step.chain_reset = step.first_chain_data | step.second_chain_data;
      step.shown_plane = scan_plane;
      step.column_bits = frame_words[scan_plane][scan_row];
      pending_steps.push_back(step);
      scan_row = (int'(scan_row) + 1 >= Rows) ? 4'd0 : scan_row + 4'd1;
    end
  endtask

  task automatic check_step(input out_t got);
    out_t want;
    if (pending_steps.size() == 0) begin
      note_error("row step with none pending", 32'(got), '0);
    end else begin
      want = pending_steps.pop_front();
      if (got.column_bits !== want.column_bits)
        note_error("column_bits", 32'(got.column_bits), 32'(want.column_bits));
      if (got.chain_reset !== want.chain_reset)
        note_error("chain_reset", 32'(got.chain_reset), 32'(want.chain_reset));
      if (got.first_chain_data !== want.first_chain_data)
        note_error("first_chain_data", 32'(got.first_chain_data),
                   32'(want.first_chain_data));
      if (got.second_chain_data !== want.second_chain_data)
        note_error("second_chain_data", 32'(got.second_chain_data),
                   32'(want.second_chain_data));
      if (got.shown_row !== want.shown_row)
        note_error("shown_row", 32'(got.shown_row), 32'(want.shown_row));
      if (got.shown_plane !== want.shown_plane)
        note_error("shown_plane", 32'(got.shown_plane), 32'(want.shown_plane));
    end
  endtask

  // monitor: prediction and checking on the rising edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_accepted <= 1'b0;
    end else begin
      req_accepted <= in_valid_i && (in_stall_o === 1'b0);
      if (cfg_valid_i && (cfg_ready_o === 1'b1))
        load_register(cfg_idx_e'(cfg_index_i), cfg_data_i);
      if (in_valid_i && (in_stall_o === 1'b0)) advance_scanner(in_data_i);
      if ((out_valid_o === 1'b1) && !out_stall_i) check_step(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // driver: a held request stays put until taken
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !req_accepted)) begin
      if (queued_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= queued_reqs.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_idle_pct);
  end

  task automatic queue_write(input logic [1:0] plane, input logic [3:0] row,
                             input logic [15:0] word);
    in_t req;
    req.cmd         = CMD_WRITE;
    req.write_plane = plane;
    req.write_row   = row;
    req.write_word  = word;
    queued_reqs.push_back(req);
  endtask

  // ticks carry random write fields, which the block must ignore
  task automatic queue_random(input int unsigned count, input int unsigned write_pct);
    in_t req;
    for (int unsigned i = 0; i < count; i++) begin
      req.cmd         = ($urandom_range(99) < write_pct) ? CMD_WRITE : CMD_TICK;
      req.write_plane = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
      req.write_row   = 4'($urandom_range(15));
      case ($urandom_range(7))
        0:       req.write_word = 16'h0000;
        1:       req.write_word = 16'hffff;
        default: req.write_word = 16'($urandom);
      endcase
      queued_reqs.push_back(req);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // sender holds off until every pending row step has come out
  task automatic wait_quiet();
    while (queued_reqs.size() != 0 || in_valid_i || pending_steps.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin
    reset_scanner_model();
    set_idling(27, 50);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // extremes of plane, row and word, including the unshown plane
    queue_write(2'd0, 4'd0,  16'hffff);
    queue_write(2'd0, 4'd15, 16'h0001);
    queue_write(2'd1, 4'd8,  16'haaaa);
    queue_write(2'd1, 4'd15, 16'hffff);
    queue_write(2'd2, 4'd0,  16'h5555);
    queue_write(2'd2, 4'd15, 16'h8000);
    queue_write(2'd3, 4'd0,  16'h1234);
    queue_write(2'd3, 4'd15, 16'hffff);
    queue_write(2'd1, 4'd0,  16'h0000);
    queue_write(2'd2, 4'd8,  16'h7ffe);
    queue_random(14, 0);

    // reset periods still in force
    queue_random(300, 15);
    wait_quiet();

    // all periods zero: every tick fires a row step once the tick counter is back at zero
    write_reg(REG_PERIOD_P0, 8'd0);
    write_reg(REG_PERIOD_P1, 8'd0);
    write_reg(REG_PERIOD_P2, 8'd0);
    write_reg(REG_STARTUP,   8'd0);
    queue_random(250, 25);
    wait_quiet();

    set_idling(50, 27);
    write_reg(REG_PERIOD_P0, 8'd255);
    write_reg(REG_PERIOD_P1, 8'd0);
    write_reg(REG_PERIOD_P2, 8'd1);
    write_reg(REG_STARTUP,   8'd255);
    queue_random(200, 10);
    wait_quiet();

    // leave the counter above a new compare so it must wrap through 255
    write_reg(REG_STARTUP, 8'd200);
    queue_random(60, 0);
    wait_quiet();
    if (tick_count != 8'd0)
      write_reg(REG_STARTUP, 8'($urandom_range(int'(tick_count) - 1)));
    write_reg(REG_PERIOD_P0, 8'($urandom_range(7)));
    write_reg(REG_PERIOD_P1, 8'($urandom_range(7)));
    write_reg(REG_PERIOD_P2, 8'($urandom_range(7)));
    queue_random(320, 10);
    wait_quiet();

    set_idling(0, 0);
    write_reg(REG_PERIOD_P0, 8'($urandom_range(6)));
    write_reg(REG_PERIOD_P1, 8'($urandom_range(6)));
    write_reg(REG_PERIOD_P2, 8'($urandom_range(6)));
    write_reg(REG_STARTUP,   8'($urandom_range(6)));
    queue_random(300, 20);
    wait_quiet();

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### led_matrix_bitplane_scanner.f
+incdir+rtl
rtl/lmbs_pkg.sv
rtl/lmbs_ram.sv
rtl/lmbs_ctrl.sv
rtl/led_matrix_bitplane_scanner.sv
tb/testbench.sv
